FILE: design/pdbs_pkg.sv
// ----------------------------------------------------------------------------
// pdbs_pkg
// Shared types and constants of the point depth buffer splatter.
// ----------------------------------------------------------------------------
package pdbs_pkg;

	localparam int SCREEN_WIDTH_DEF  = 120;
	localparam int SCREEN_HEIGHT_DEF = 100;
	localparam int DEPTH_SPAN_DEF    = 120;

	localparam int CRD_W = 10;

	localparam logic [15:0] X_OFFSET_RST = 16'd15360;
	localparam logic [15:0] Y_OFFSET_RST = 16'd15488;

	localparam logic OP_PLOT = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic CFG_X_OFFSET = 1'b0;
	localparam logic CFG_Y_OFFSET = 1'b1;

	typedef struct packed {
		logic              opcode;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic [7:0]        red;
		logic [7:0]        green;
		logic [7:0]        blue;
		logic [6:0]        column;
		logic [6:0]        row;
	} pdbs_in_t;

	typedef struct packed {
		logic       covered;
		logic [7:0] shade_red;
		logic [7:0] shade_green;
		logic [7:0] shade_blue;
	} pdbs_out_t;

	typedef struct packed {
		logic             inb;
		logic [CRD_W-1:0] px;
		logic [CRD_W-1:0] py;
	} coord_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] z;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} pix_t;

endpackage

FILE: design/pdbs_ram.sv
// ----------------------------------------------------------------------------
// pdbs_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pdbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/pdbs_coord.sv
// ----------------------------------------------------------------------------
// pdbs_coord
// Maps an incoming item to a screen position: offsets and rounds a plotted
// point, or takes the pixel address of a read, and checks the screen bounds.
// ----------------------------------------------------------------------------
module pdbs_coord import pdbs_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  pdbs_in_t    item,
	input  logic [15:0] x_offset,
	input  logic [15:0] y_offset,
	output coord_t      coord
);

	localparam int CMP_W = CRD_W + 1;

	// Rounds half away from zero; the top bit tells whether the result is
	// not negative.
	function automatic logic [CRD_W:0] round_axis(input logic [15:0] v,
			input logic [15:0] off);
		logic [17:0] s;
		logic [17:0] mag;
		logic [17:0] r;
		s = {{2{v[15]}}, v} + {2'b00, off};
		mag = s[17] ? (18'd0 - s) : s;
		r = (mag + 18'd128) >> 8;
		return {(!s[17] || r == 18'd0), r[CRD_W-1:0]};
	endfunction

	logic [CRD_W:0]   rx;
	logic [CRD_W:0]   ry;
	logic [CRD_W-1:0] cx;
	logic [CRD_W-1:0] cy;
	logic             x_ok;
	logic             y_ok;

	always_comb begin
		rx = round_axis(item.x, x_offset);
		ry = round_axis(item.y, y_offset);
		if (item.opcode == OP_PLOT) begin
			cx = rx[CRD_W-1:0];
			cy = ry[CRD_W-1:0];
			x_ok = rx[CRD_W];
			y_ok = ry[CRD_W];
		end else begin
			cx = CRD_W'(item.column);
			cy = CRD_W'(item.row);
			x_ok = 1'b1;
			y_ok = 1'b1;
		end
		coord.px = cx;
		coord.py = cy;
		coord.inb = x_ok && y_ok
			&& (CMP_W'(cx) < CMP_W'(SCREEN_WIDTH))
			&& (CMP_W'(cy) < CMP_W'(SCREEN_HEIGHT));
	end

endmodule

FILE: design/pdbs_shade.sv
// ----------------------------------------------------------------------------
// pdbs_shade
// Scales one color channel by the normalized depth with round-half-up, as a
// short pipeline: product, reciprocal multiply, and a one-step correction.
// ----------------------------------------------------------------------------
module pdbs_shade import pdbs_pkg::*; #(
	parameter int DEPTH_SPAN = DEPTH_SPAN_DEF,
	localparam int DEN = DEPTH_SPAN * 256,
	localparam int N_W = $clog2(DEN + 1)
) (
	input  logic           clk,
	input  logic [7:0]     color,
	input  logic [N_W-1:0] depth_num,
	output logic [7:0]     shade
);

	localparam int P_W = N_W + 10;
	localparam int S_W = P_W - 9;
	localparam int Q_W = S_W + 17;
	localparam logic [16:0] RECIP = 17'((32'd1 << 16) / DEPTH_SPAN);

	logic [P_W-1:0] prod;
	logic [P_W-1:0] prod_s3;
	logic [S_W-1:0] pshift;
	logic [Q_W-1:0] qprod;
	logic [7:0]     q0_s4;
	logic [S_W-1:0] pshift_s4;
	logic [S_W-1:0] rem;

	assign prod = ((P_W'(color) * P_W'(depth_num)) << 1) + P_W'(DEN);
	assign pshift = prod_s3[P_W-1:9];
	assign qprod = Q_W'(pshift) * Q_W'(RECIP);

	always_ff @(posedge clk) begin
		prod_s3 <= prod;
		q0_s4 <= qprod[23:16];
		pshift_s4 <= pshift;
	end

	// The reciprocal estimate is low by at most one.
	assign rem = pshift_s4 - S_W'(q0_s4) * S_W'(DEPTH_SPAN);
	assign shade = (rem >= S_W'(DEPTH_SPAN)) ? (q0_s4 + 8'd1) : q0_s4;

endmodule

FILE: design/point_depth_buffer_splatter_unit.sv
// ----------------------------------------------------------------------------
// point_depth_buffer_splatter_unit
// Point splatter with a depth buffer held in one pixel memory.
// ----------------------------------------------------------------------------
// An item is taken on item when start is high and busy is low. A plot item
// offsets and rounds its point and, when it lands on the screen, stores it if
// the pixel is empty or the new z is strictly greater than the stored one. A
// read item returns one pixel on result, marked by done for one cycle, and
// clears that pixel in the memory.
// Every item is one read-modify-write of the pixel memory: busy stays high
// through ST_INDEX, ST_READ and ST_MODIFY after a plot is accepted, and for
// a read also through ST_SCALE, ST_QUOT and ST_FIX, which run the depth
// scaling multiply pipeline; the result is then registered and shown with done.
// The receiver cannot stall: each result is a single-cycle transfer.
// The cfg channel writes x_offset (index 0) and y_offset (index 1); it is
// always ready and should be used while the block is idle.
// After reset the block clears the pixel memory, one entry per cycle, all
// SCREEN_WIDTH * SCREEN_HEIGHT entries (12000 by default), with busy high.
// ----------------------------------------------------------------------------
module point_depth_buffer_splatter_unit import pdbs_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
	parameter int DEPTH_SPAN    = DEPTH_SPAN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  pdbs_in_t    item,
	output logic        done,
	output pdbs_out_t   result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ADDR_W = 2 * CRD_W + 1;
	localparam int DEN    = DEPTH_SPAN * 256;
	localparam int N_W    = $clog2(DEN + 1);
	localparam int PIX_W  = $bits(pix_t);

	typedef enum logic [7:0] {
		ST_CLEAR  = 8'b0000_0001,
		ST_IDLE   = 8'b0000_0010,
		ST_INDEX  = 8'b0000_0100,
		ST_READ   = 8'b0000_1000,
		ST_MODIFY = 8'b0001_0000,
		ST_SCALE  = 8'b0010_0000,
		ST_QUOT   = 8'b0100_0000,
		ST_FIX    = 8'b1000_0000
	} state_t;

	state_t           state_q;
	state_t           state_d;
	logic [IDX_W-1:0] clr_cnt_q;
	logic [15:0]      x_offset_q;
	logic [15:0]      y_offset_q;
	logic             accept;
	coord_t           coord;

	logic             op_q;
	logic             inb_q;
	logic [CRD_W-1:0] px_q;
	logic [CRD_W-1:0] py_q;
	logic [15:0]      z_q;
	logic [7:0]       red_q;
	logic [7:0]       green_q;
	logic [7:0]       blue_q;
	logic [IDX_W-1:0] addr_q;
	logic [ADDR_W-1:0] addr_full;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	pix_t             mem_wdata;
	logic             mem_re;
	logic [PIX_W-1:0] mem_rdata;
	pix_t             rd_pix;

	logic signed [17:0] zsum;
	logic [N_W-1:0]   num;
	logic [N_W-1:0]   num_s2;
	logic [7:0]       red_s2;
	logic [7:0]       green_s2;
	logic [7:0]       blue_s2;
	logic             covered_s2;
	logic [7:0]       shade_r;
	logic [7:0]       shade_g;
	logic [7:0]       shade_b;
	logic             done_q;
	pdbs_out_t        result_q;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign cfg_ready = 1'b1;
	assign done = done_q;
	assign result = result_q;

	pdbs_coord #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_coord (
		.item    (item),
		.x_offset(x_offset_q),
		.y_offset(y_offset_q),
		.coord   (coord)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_offset_q <= X_OFFSET_RST;
			y_offset_q <= Y_OFFSET_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_X_OFFSET: x_offset_q <= cfg_data;
				CFG_Y_OFFSET: y_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == IDX_W'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_INDEX;
				end
			end
			ST_INDEX:  state_d = ST_READ;
			ST_READ:   state_d = ST_MODIFY;
			ST_MODIFY: state_d = (op_q == OP_READ) ? ST_SCALE : ST_IDLE;
			ST_SCALE:  state_d = ST_QUOT;
			ST_QUOT:   state_d = ST_FIX;
			ST_FIX:    state_d = ST_IDLE;
			default:   state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == ST_FIX);
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= item.opcode;
			inb_q <= coord.inb;
			px_q <= coord.px;
			py_q <= coord.py;
			z_q <= item.z;
			red_q <= item.red;
			green_q <= item.green;
			blue_q <= item.blue;
		end
		if (state_q == ST_INDEX) begin
			addr_q <= addr_full[IDX_W-1:0];
		end
	end

	assign addr_full = ADDR_W'(px_q) + ADDR_W'(py_q) * ADDR_W'(SCREEN_WIDTH);

	assign rd_pix = pix_t'(mem_rdata);
	assign mem_re = (state_q == ST_READ);

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_waddr = clr_cnt_q;
		end else if (state_q == ST_MODIFY && inb_q) begin
			if (op_q == OP_READ) begin
				mem_we = 1'b1;
			end else if (!rd_pix.valid || $signed(z_q) > $signed(rd_pix.z)) begin
				mem_we = 1'b1;
				mem_wdata = '{valid: 1'b1, z: z_q, red: red_q, green: green_q,
					blue: blue_q};
			end
		end
	end

	pdbs_ram #(
		.WIDTH(PIX_W),
		.DEPTH(DEPTH)
	) u_pixels (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(addr_q),
		.rdata(mem_rdata)
	);

	assign zsum = 18'(signed'(rd_pix.z)) + 18'(DEPTH_SPAN * 128);

	always_comb begin
		if (zsum[17]) begin
			num = '0;
		end else if (zsum > 18'(DEN)) begin
			num = N_W'(DEN);
		end else begin
			num = zsum[N_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MODIFY) begin
			num_s2 <= num;
			red_s2 <= rd_pix.red;
			green_s2 <= rd_pix.green;
			blue_s2 <= rd_pix.blue;
			covered_s2 <= inb_q && rd_pix.valid;
		end
		if (state_q == ST_FIX) begin
			result_q.covered <= covered_s2;
			result_q.shade_red <= covered_s2 ? shade_r : 8'd0;
			result_q.shade_green <= covered_s2 ? shade_g : 8'd0;
			result_q.shade_blue <= covered_s2 ? shade_b : 8'd0;
		end
	end

	pdbs_shade #(.DEPTH_SPAN(DEPTH_SPAN)) u_shade_r (
		.clk      (clk),
		.color    (red_s2),
		.depth_num(num_s2),
		.shade    (shade_r)
	);

	pdbs_shade #(.DEPTH_SPAN(DEPTH_SPAN)) u_shade_g (
		.clk      (clk),
		.color    (green_s2),
		.depth_num(num_s2),
		.shade    (shade_g)
	);

	pdbs_shade #(.DEPTH_SPAN(DEPTH_SPAN)) u_shade_b (
		.clk      (clk),
		.color    (blue_s2),
		.depth_num(num_s2),
		.shade    (shade_b)
	);

	a_done_after_fix: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_FIX))
		else $error("done without a finished read");

	a_done_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (op_q == OP_READ))
		else $error("plot item produced a result");

	a_clear_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (mem_we && !mem_wdata.valid))
		else $error("clearing pass wrote a valid pixel");

	a_cover_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.covered) |-> inb_q)
		else $error("covered result for a pixel off the screen");

endmodule

FILE: tb/tb_point_depth_buffer_splatter_unit.sv
// ----------------------------------------------------------------------------
// tb_point_depth_buffer_splatter_unit
// Self-checking bench for the point depth buffer splatter.
// ----------------------------------------------------------------------------
// A short directed sequence probes reset contents, out-of-range reads, screen
// edges, rounding at the half, depth ties and depth saturation. Random plots
// and reads then run under several offset settings and sender gap rates,
// with most traffic aimed at a small pool of pixels so depth contests and
// read-back clears happen often. A local depth buffer model predicts every
// read result, and each result transfer is compared with the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_point_depth_buffer_splatter_unit;
	import pdbs_pkg::*;

	localparam int SCR_W     = SCREEN_WIDTH_DEF;
	localparam int SCR_H     = SCREEN_HEIGHT_DEF;
	localparam int SPAN      = DEPTH_SPAN_DEF;
	localparam int PIX_TOTAL = SCR_W * SCR_H;
	localparam int MAX_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOT_PIXELS = 8;
	localparam pdbs_out_t BLANK_PIX = '0;

	typedef struct {
		pdbs_in_t  op;
		bit        typed;
		pdbs_out_t want;
	} vec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	pdbs_in_t    item = '0;
	logic        done;
	pdbs_out_t   result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_X_OFFSET;
	logic [15:0] cfg_data = '0;

	bit               pix_valid [PIX_TOTAL];
	logic signed [15:0] pix_z [PIX_TOTAL];
	logic [7:0]       pix_r [PIX_TOTAL];
	logic [7:0]       pix_g [PIX_TOTAL];
	logic [7:0]       pix_b [PIX_TOTAL];
	logic [15:0]      x_off = X_OFFSET_RST;
	logic [15:0]      y_off = Y_OFFSET_RST;

	pdbs_out_t expected_pixels [$];
	pdbs_out_t want_pix;
	vec_t      directed_vecs [$];
	int        hot_col [HOT_PIXELS];
	int        hot_row [HOT_PIXELS];
	int        mismatches = 0;
	int        reads_checked = 0;
	int        items_sent = 0;
	int        offset_writes = 0;
	int        cycles = 0;

	point_depth_buffer_splatter_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= MAX_CYCLES) begin
			$display("Timeout after %0d cycles with %0d results outstanding.", cycles,
				expected_pixels.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int round_q88(int v);
		if (v >= 0) begin
			return (v + 128) >>> 8;
		end
		return -((-v + 128) >>> 8);
	endfunction

	function automatic logic [7:0] scale_by_depth(logic [7:0] c, int n);
		int den;
		den = SPAN * 256;
		return 8'((2 * int'(c) * n + den) / (2 * den));
	endfunction

	// Returns 1 when the item produces a result, which is placed in res.
	function automatic bit splat_predict(input pdbs_in_t it, output pdbs_out_t res);
		int sx;
		int sy;
		int idx;
		int n;
		res = '0;
		if (it.opcode == OP_PLOT) begin
			sx = round_q88(int'($signed(it.x)) + int'(x_off));
			sy = round_q88(int'($signed(it.y)) + int'(y_off));
			if (sx < 0 || sx >= SCR_W || sy < 0 || sy >= SCR_H) begin
				return 1'b0;
			end
			idx = sx + sy * SCR_W;
			if (!pix_valid[idx] || int'(pix_z[idx]) < int'($signed(it.z))) begin
				pix_valid[idx] = 1'b1;
				pix_z[idx] = it.z;
				pix_r[idx] = it.red;
				pix_g[idx] = it.green;
				pix_b[idx] = it.blue;
			end
			return 1'b0;
		end
		if (int'(it.column) >= SCR_W || int'(it.row) >= SCR_H) begin
			return 1'b1;
		end
		idx = int'(it.column) + int'(it.row) * SCR_W;
		if (!pix_valid[idx]) begin
			return 1'b1;
		end
		n = int'(pix_z[idx]) + SPAN * 128;
		if (n < 0) begin
			n = 0;
		end
		if (n > SPAN * 256) begin
			n = SPAN * 256;
		end
		res.covered = 1'b1;
		res.shade_red = scale_by_depth(pix_r[idx], n);
		res.shade_green = scale_by_depth(pix_g[idx], n);
		res.shade_blue = scale_by_depth(pix_b[idx], n);
		pix_valid[idx] = 1'b0;
		return 1'b1;
	endfunction

	function automatic pdbs_in_t plot_item(logic [15:0] x, logic [15:0] y, logic [15:0] z,
		logic [7:0] r, logic [7:0] g, logic [7:0] b);
		pdbs_in_t it;
		it = '{opcode: OP_PLOT, x: x, y: y, z: z, red: r, green: g, blue: b,
			column: 7'h7F, row: 7'h7F};
		return it;
	endfunction

	function automatic pdbs_in_t read_item(int col, int rw);
		pdbs_in_t it;
		it = '{opcode: OP_READ, x: 16'hFFFF, y: 16'hFFFF, z: 16'hFFFF, red: 8'hFF,
			green: 8'hFF, blue: 8'hFF, column: 7'(col), row: 7'(rw)};
		return it;
	endfunction

	// Most plots land near a chosen pixel and most reads hit one, so the
	// buffer sees depth contests and read-back clears; the rest is full range.
	function automatic pdbs_in_t random_op();
		pdbs_in_t it;
		int pick;
		int slot;
		int sx;
		int sy;
		it.opcode = ($urandom_range(0, 99) < 55) ? OP_PLOT : OP_READ;
		it.x = 16'($urandom);
		it.y = 16'($urandom);
		it.z = 16'($urandom);
		it.red = 8'($urandom);
		it.green = 8'($urandom);
		it.blue = 8'($urandom);
		it.column = 7'($urandom);
		it.row = 7'($urandom);
		pick = $urandom_range(0, 99);
		slot = $urandom_range(0, HOT_PIXELS - 1);
		sx = (pick < 60) ? hot_col[slot] : $urandom_range(0, SCR_W - 1);
		sy = (pick < 60) ? hot_row[slot] : $urandom_range(0, SCR_H - 1);
		if (pick < 85) begin
			if (it.opcode == OP_PLOT) begin
				it.x = 16'(sx * 256 - int'(x_off) + int'($urandom_range(0, 255)) - 128);
				it.y = 16'(sy * 256 - int'(y_off) + int'($urandom_range(0, 255)) - 128);
				if ($urandom_range(0, 1) == 0) begin
					it.z = 16'((int'($urandom_range(0, 6)) - 3) * 64);
				end
			end else begin
				it.column = 7'(sx);
				it.row = 7'(sy);
			end
		end
		return it;
	endfunction

	task automatic add_row(pdbs_in_t op, bit typed, pdbs_out_t want);
		vec_t v;
		v.op = op;
		v.typed = typed;
		v.want = want;
		directed_vecs.insert(directed_vecs.size(), v);
	endtask

	task automatic drive_item(pdbs_in_t it, bit typed, pdbs_out_t want, int idle_pct);
		pdbs_out_t res;
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy !== 1'b0);
		items_sent++;
		if (splat_predict(it, res)) begin
			expected_pixels.insert(expected_pixels.size(), typed ? want : res);
		end
	endtask

	// Plots give no result, so the task waits for busy to fall as well as for the queue to empty, then drains.
	task automatic settle();
		start <= 1'b0;
		while (expected_pixels.size() != 0 || busy !== 1'b0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		offset_writes++;
		if (idx == CFG_X_OFFSET) begin
			x_off = val;
		end else begin
			y_off = val;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("Unexpected result transfer at cycle %0d: covered %0b rgb %0d/%0d/%0d",
						cycles, result.covered, result.shade_red, result.shade_green,
						result.shade_blue);
				end
			end else begin
				want_pix = expected_pixels.pop_front();
				reads_checked++;
				if (result.covered !== want_pix.covered ||
					result.shade_red !== want_pix.shade_red ||
					result.shade_green !== want_pix.shade_green ||
					result.shade_blue !== want_pix.shade_blue) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Mismatch at cycle %0d: expected covered %0b rgb %0d/%0d/%0d, %s",
							cycles, want_pix.covered, want_pix.shade_red, want_pix.shade_green,
							want_pix.shade_blue, $sformatf("got covered %0b rgb %0d/%0d/%0d",
							result.covered, result.shade_red, result.shade_green,
							result.shade_blue));
					end
				end
			end
		end
	end

	initial begin
		logic [15:0] phase_x [4];
		logic [15:0] phase_y [4];
		int phase_len [4];
		int phase_idle [4];
		int p;
		int k;

		add_row(read_item(0, 0), 1'b1, BLANK_PIX);
		add_row(read_item(SCR_W - 1, SCR_H - 1), 1'b1, BLANK_PIX);
		add_row(read_item(127, 127), 1'b1, BLANK_PIX);
		add_row(read_item(SCR_W, 5), 1'b1, BLANK_PIX);
		add_row(read_item(0, SCR_H), 1'b1, BLANK_PIX);
		add_row(plot_item(16'h0000, 16'h0000, 16'h0000, 8'd255, 8'd255, 8'd255), 1'b0, '0);
		add_row(read_item(60, 61), 1'b1, pdbs_out_t'{1'b1, 8'd128, 8'd128, 8'd128});
		add_row(read_item(60, 61), 1'b1, BLANK_PIX);
		add_row(plot_item(16'h0000, 16'h0000, 16'h7FFF, 8'd255, 8'd0, 8'd170), 1'b0, '0);
		add_row(plot_item(16'h0000, 16'h0000, 16'h8000, 8'd1, 8'd2, 8'd3), 1'b0, '0);
		add_row(read_item(60, 61), 1'b1, pdbs_out_t'{1'b1, 8'd255, 8'd0, 8'd170});
		add_row(plot_item(16'h0000, 16'h0000, 16'h0100, 8'd10, 8'd20, 8'd30), 1'b0, '0);
		add_row(plot_item(16'h0000, 16'h0000, 16'h0100, 8'd40, 8'd50, 8'd60), 1'b0, '0);
		add_row(read_item(60, 61), 1'b0, '0);
		add_row(plot_item(16'h0000, 16'h0000, 16'h8000, 8'd255, 8'd255, 8'd255), 1'b0, '0);
		add_row(plot_item(16'h0000, 16'h0000, 16'h8001, 8'd200, 8'd100, 8'd50), 1'b0, '0);
		add_row(read_item(60, 61), 1'b1, pdbs_out_t'{1'b1, 8'd0, 8'd0, 8'd0});
		add_row(plot_item(16'h3B00, 16'h2680, 16'h1000, 8'd90, 8'd180, 8'd255), 1'b0, '0);
		add_row(read_item(SCR_W - 1, SCR_H - 1), 1'b0, '0);
		add_row(plot_item(16'h3B80, 16'h0000, 16'h7FFF, 8'd1, 8'd1, 8'd1), 1'b0, '0);
		add_row(read_item(SCR_W - 1, 61), 1'b1, BLANK_PIX);
		add_row(plot_item(16'hC380, 16'h0000, 16'h7FFF, 8'd7, 8'd7, 8'd7), 1'b0, '0);
		add_row(plot_item(16'hC381, 16'h0000, 16'h0000, 8'd255, 8'd128, 8'd64), 1'b0, '0);
		add_row(read_item(0, 61), 1'b0, '0);
		add_row(plot_item(16'h7FFF, 16'h8000, 16'h7FFF, 8'd255, 8'd255, 8'd255), 1'b0, '0);
		add_row(plot_item(16'h8000, 16'h7FFF, 16'h7FFF, 8'd255, 8'd255, 8'd255), 1'b0, '0);

		phase_x = '{16'h0000, 16'hFFFF, X_OFFSET_RST, 16'($urandom_range(0, 16'h7FFF))};
		phase_y = '{16'h0000, 16'hFFFF, Y_OFFSET_RST, 16'($urandom_range(0, 16'h7FFF))};
		phase_len = '{150, 60, 200, 170};
		phase_idle = '{0, 60, 8, 0};

		do @(posedge clk); while (!arst_n);
		foreach (directed_vecs[i]) begin
			drive_item(directed_vecs[i].op, directed_vecs[i].typed, directed_vecs[i].want, 0);
		end
		settle();

		for (p = 0; p < 4; p++) begin
			write_reg(CFG_X_OFFSET, phase_x[p]);
			write_reg(CFG_Y_OFFSET, phase_y[p]);
			cfg_valid <= 1'b0;
			for (k = 0; k < HOT_PIXELS; k++) begin
				hot_col[k] = $urandom_range(0, SCR_W - 1);
				hot_row[k] = $urandom_range(0, SCR_H - 1);
			end
			for (k = 0; k < phase_len[p]; k++) begin
				if (k == phase_len[p] / 2) begin
					settle();
				end
				drive_item(random_op(), 1'b0, '0, phase_idle[p]);
			end
			settle();
		end

		$display("Summary: %0d items (%0d directed), %0d pixel reads checked, %0d offset writes.",
			items_sent, directed_vecs.size(), reads_checked, offset_writes);
		$display("Offsets swept from zero to full scale, sender gaps from none to 60 percent.");
		if (mismatches == 0 && expected_pixels.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d results never seen.", mismatches,
				expected_pixels.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

FILE: files.f
design/pdbs_pkg.sv
design/pdbs_ram.sv
design/pdbs_coord.sv
design/pdbs_shade.sv
design/point_depth_buffer_splatter_unit.sv
tb/tb_point_depth_buffer_splatter_unit.sv
